// ===== hw/rtl/timed_event_delivery_queue_top_macros.svh =====
// assertion macros for the timed event delivery queue
`ifndef TIMED_EVENT_DELIVERY_QUEUE_TOP_MACROS_SVH
`define TIMED_EVENT_DELIVERY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// condition must hold on every clock edge outside reset
`define TEDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequence must hold in the cycle after the antecedent
`define TEDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TEDQ_ASSERT(lbl, prop, msg)
`define TEDQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tedq_pkg.sv =====
package tedq_pkg;

  // table geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEST_W = 8;
  localparam int unsigned PAY_W  = 16;
  localparam int unsigned KIND_W = 2;

  // request codes
  localparam logic REQ_SCHED = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED = 2'd0,
    KIND_DELIV = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_CMP,
    ST_END
  } state_e;

  // one stored event
  typedef struct packed {
    logic [TIME_W-1:0] etime;
    logic [DEST_W-1:0] dest;
    logic [PAY_W-1:0]  pay;
  } entry_t;

endpackage

// ===== hw/rtl/tedq_in_if.sv =====
interface tedq_in_if;
  import tedq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] event_time;
  logic [DEST_W-1:0] dest_id;
  logic [PAY_W-1:0]  payload;

  modport source (
    output valid, req_type, event_time, dest_id, payload,
    input  ready
  );

  modport sink (
    input  valid, req_type, event_time, dest_id, payload,
    output ready
  );
endinterface

// ===== hw/rtl/tedq_out_if.sv =====
interface tedq_out_if;
  import tedq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              accepted;
  logic [DEST_W-1:0] out_dest;
  logic [PAY_W-1:0]  out_payload;
  logic [TIME_W-1:0] now;
  logic              last;

  modport source (
    output valid, kind, accepted, out_dest, out_payload, now, last,
    input  ready
  );

  modport sink (
    input  valid, kind, accepted, out_dest, out_payload, now, last,
    output ready
  );
endinterface

// ===== hw/rtl/tedq_ram.sv =====
module tedq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/timed_event_delivery_queue_top.sv =====
// Timed event delivery queue. A schedule item appends its event to a table of
// tedq_pkg::CAPACITY entries (or is refused when full) and answers with one result
// through ST_RESP and the output register. A tick item walks the stored entries one
// per cycle, unless a second match waits for a busy output register, through a table
// RAM with one read and one write port and one time comparator: matching entries go
// out as delivered items in table order, the rest are written back compacted, and
// current time then increments. Results leave through the output register, and a
// new item is accepted once the previous one has been fully handed to that register.
// Writing start_time also loads current time.
module timed_event_delivery_queue_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tedq_in_if.sink                  req_i,
  tedq_out_if.source               rsp_o,
  input  logic                     cfg_we_i,
  input  logic [tedq_pkg::TIME_W-1:0] cfg_wdata_i
);
  import tedq_pkg::*;

  `include "timed_event_delivery_queue_top_macros.svh"

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]  rd_idx_nxt;
  logic [TIME_W-1:0] now_q, now_d;
  logic              acc_q, acc_d;

  // last match held back until we know whether another follows
  logic              held_vld_q, held_vld_d;
  logic [DEST_W-1:0] held_dest_q, held_dest_d;
  logic [PAY_W-1:0]  held_pay_q, held_pay_d;

  // output register
  logic              ov_q, ov_d;
  kind_e             o_kind_q, o_kind_d;
  logic              o_acc_q, o_acc_d;
  logic [DEST_W-1:0] o_dest_q, o_dest_d;
  logic [PAY_W-1:0]  o_pay_q, o_pay_d;
  logic [TIME_W-1:0] o_now_q, o_now_d;
  logic              o_last_q, o_last_d;
  logic              out_load;
  logic              out_free;

  // table ram
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  logic              match;

  // tick finishing this cycle with no start time write
  logic              tick_done;

  tedq_ram #(
    .Width ($bits(entry_t)),
    .Depth (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !ov_q || rsp_o.ready;
  assign match      = (ram_rdata.etime == now_q);
  assign rd_idx_nxt = rd_idx_q + CNT_W'(1);
  assign req_i.ready = (state_q == ST_IDLE);
  assign tick_done  = (state_q == ST_END) && out_free && !cfg_we_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    now_d       = now_q;
    acc_d       = acc_q;
    held_vld_d  = held_vld_q;
    held_dest_d = held_dest_q;
    held_pay_d  = held_pay_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_q[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_nxt[IDX_W-1:0];
    out_load    = 1'b0;
    o_kind_d    = KIND_EMPTY;
    o_acc_d     = 1'b0;
    o_dest_d    = '0;
    o_pay_d     = '0;
    o_now_d     = now_q;
    o_last_d    = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == REQ_SCHED) begin
            // append when there is room
            acc_d = 1'b0;
            if (cnt_q < CNT_W'(CAPACITY)) begin
              ram_we          = 1'b1;
              ram_waddr       = cnt_q[IDX_W-1:0];
              ram_wdata.etime = req_i.event_time;
              ram_wdata.dest  = req_i.dest_id;
              ram_wdata.pay   = req_i.payload;
              cnt_d           = cnt_q + CNT_W'(1);
              acc_d           = 1'b1;
            end
            state_d = ST_RESP;
          end else begin
            // start the scan at entry zero
            rd_idx_d   = '0;
            wr_idx_d   = '0;
            held_vld_d = 1'b0;
            if (cnt_q == '0) begin
              state_d = ST_END;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = ST_CMP;
            end
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = KIND_SCHED;
          o_acc_d  = acc_q;
          state_d  = ST_IDLE;
        end
      end
      ST_CMP: begin
        // a second match has to push the held one out first
        if (!match || !held_vld_q || out_free) begin
          if (!match) begin
            ram_we   = 1'b1;
            wr_idx_d = wr_idx_q + CNT_W'(1);
          end else begin
            if (held_vld_q) begin
              out_load = 1'b1;
              o_kind_d = KIND_DELIV;
              o_dest_d = held_dest_q;
              o_pay_d  = held_pay_q;
              o_last_d = 1'b0;
            end
            held_vld_d  = 1'b1;
            held_dest_d = ram_rdata.dest;
            held_pay_d  = ram_rdata.pay;
          end
          rd_idx_d = rd_idx_nxt;
          if (rd_idx_nxt < cnt_q) begin
            ram_re = 1'b1;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (held_vld_q) begin
            o_kind_d = KIND_DELIV;
            o_dest_d = held_dest_q;
            o_pay_d  = held_pay_q;
          end else begin
            o_kind_d = KIND_EMPTY;
          end
          held_vld_d = 1'b0;
          cnt_d      = wr_idx_q;
          now_d      = now_q + TIME_W'(1);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // start time write reloads current time
    if (cfg_we_i) begin
      now_d = cfg_wdata_i;
    end
  end

  // output valid follows loads and takes
  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (rsp_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      now_q      <= '0;
      held_vld_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      held_vld_q <= held_vld_d;
      ov_q       <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    wr_idx_q    <= wr_idx_d;
    acc_q       <= acc_d;
    held_dest_q <= held_dest_d;
    held_pay_q  <= held_pay_d;
    if (out_load) begin
      o_kind_q <= o_kind_d;
      o_acc_q  <= o_acc_d;
      o_dest_q <= o_dest_d;
      o_pay_q  <= o_pay_d;
      o_now_q  <= o_now_d;
      o_last_q <= o_last_d;
    end
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.kind        = o_kind_q;
  assign rsp_o.accepted    = o_acc_q;
  assign rsp_o.out_dest    = o_dest_q;
  assign rsp_o.out_payload = o_pay_q;
  assign rsp_o.now         = o_now_q;
  assign rsp_o.last        = o_last_q;

  // checks
  `TEDQ_ASSERT(a_cnt_in_range, cnt_q <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `TEDQ_ASSERT(a_wr_behind_rd, (state_q != ST_CMP) || (wr_idx_q <= rd_idx_q), "write passed read")
  `TEDQ_ASSERT_NEXT(a_tick_advances, tick_done, now_q == $past(now_q) + TIME_W'(1), "time stuck")

endmodule
